// ----- rtl/core/src_pkg.sv -----
package src_pkg;

  localparam int unsigned ValW = 31;
  localparam logic [ValW-1:0] VAL_MAX = {ValW{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0]         ch;
    logic signed [31:0] last_val;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] item_total;
    logic            saturated;
  } out_item_t;

  typedef struct packed {
    logic [ValW-1:0] token_value;
    logic            token_bad;
    logic [1:0]      token_len;
    logic            first_dollar;
    logic            in_token;
    logic            rs_none;
    logic            rs_dollar;
    logic [ValW-1:0] rs_value;
    logic [ValW-1:0] total;
    logic            sat;
  } state_t;

  localparam state_t ST_RESET = '{
    token_value:  '0,
    token_bad:    1'b0,
    token_len:    2'd0,
    first_dollar: 1'b0,
    in_token:     1'b0,
    rs_none:      1'b1,
    rs_dollar:    1'b0,
    rs_value:     '0,
    total:        '0,
    sat:          1'b0
  };

endpackage

// ----- rtl/core/selector_range_counter.sv -----
// Selector range counter: takes one selector byte per cycle on the in_ channel and,
// on the terminating NUL item, raises out_valid with one result (item count and
// saturation flag) once that NUL has passed the input register and reached the
// output register, then starts the next selector from a clean state. Every byte is
// registered, folded into the token and total state, and the result goes to an
// output register, so the block sustains one item per cycle while in_stall is low.
// in_stall rises only while a NUL waits on an earlier result held under out_stall.
module selector_range_counter import src_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  state_t    state_r;
  state_t    state_nxt;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      s1_nul;
  logic      s1_go;
  logic      in_take;
  logic      out_take;

  src_step u_step (
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  assign s1_nul   = (s1_item_r.ch == CH_NUL);
  assign s1_go    = s1_valid_r && (!s1_nul || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        state_r <= state_nxt;
      end
      if (s1_go && s1_nul) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_go && s1_nul) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/src_step.sv -----
module src_step import src_pkg::*; (
  input  state_t    st,
  input  in_item_t  item,
  output state_t    st_nxt,
  output out_item_t res
);

  logic                is_nul;
  logic                last_neg;
  logic                is_delim;
  logic                dash_end;
  logic                is_dollar;
  logic                strict_none;
  logic                end_tok;
  logic                is_digit;
  logic [ValW-1:0]     last_v;
  logic [ValW-1:0]     hi;
  logic [ValW-1:0]     lo;
  logic                rng_zero;
  logic [ValW:0]       rng_amt;
  logic [ValW:0]       add_amt;
  logic [ValW+1:0]     sum;
  logic [ValW+3:0]     prod;
  logic [ValW-1:0]     cur_value;
  logic                cur_bad;
  logic [1:0]          cur_len;
  state_t              upd;

  assign is_nul      = (item.ch == CH_NUL);
  assign last_neg    = item.last_val[31];
  assign is_delim    = (item.ch == CH_COMMA) || ((item.ch == CH_DASH) && !last_neg);
  assign dash_end    = is_delim && (item.ch == CH_DASH);
  assign is_dollar   = st.first_dollar && (st.token_len == 2'd1);
  assign strict_none = !is_dollar && st.token_bad;
  assign end_tok     = st.in_token && (is_nul || is_delim);
  assign is_digit    = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign last_v      = item.last_val[ValW-1:0];

  // range width, clipped at last when '$' is involved
  always_comb begin
    if (st.rs_dollar) begin
      hi       = last_v;
      lo       = st.token_value;
      rng_zero = is_dollar || (st.token_value > last_v);
    end else if (is_dollar) begin
      hi       = last_v;
      lo       = st.rs_value;
      rng_zero = (st.rs_value > last_v);
    end else if (st.token_value > st.rs_value) begin
      hi       = st.token_value;
      lo       = st.rs_value;
      rng_zero = 1'b0;
    end else begin
      hi       = st.rs_value;
      lo       = st.token_value;
      rng_zero = 1'b0;
    end
    rng_amt = rng_zero ? '0 : ({1'b0, hi} - {1'b0, lo} + {{ValW{1'b0}}, 1'b1});
  end

  always_comb begin
    upd     = st;
    add_amt = '0;
    if (end_tok) begin
      upd.in_token = 1'b0;
      if (last_neg) begin
        add_amt = {{ValW{1'b0}}, 1'b1};
      end else if (dash_end) begin
        upd.rs_none   = strict_none;
        upd.rs_dollar = is_dollar;
        upd.rs_value  = st.token_value;
      end else if (!st.rs_none && !strict_none) begin
        add_amt       = rng_amt;
        upd.rs_none   = 1'b1;
        upd.rs_dollar = 1'b0;
      end else if (st.token_value <= last_v) begin
        add_amt = {{ValW{1'b0}}, 1'b1};
      end
    end
    sum = {2'b00, st.total} + {1'b0, add_amt};
    if (sum > {2'b00, VAL_MAX}) begin
      upd.total = VAL_MAX;
      upd.sat   = 1'b1;
    end else begin
      upd.total = sum[ValW-1:0];
    end
  end

  // token byte
  always_comb begin
    if (st.in_token) begin
      cur_value = st.token_value;
      cur_bad   = st.token_bad;
      cur_len   = st.token_len;
    end else begin
      cur_value = '0;
      cur_bad   = 1'b0;
      cur_len   = 2'd0;
    end
    prod = ({4'b0, cur_value} << 3) + ({4'b0, cur_value} << 1)
         + {{ValW{1'b0}}, item.ch[3:0]};
  end

  always_comb begin
    res.item_total = upd.total;
    res.saturated  = upd.sat;
    st_nxt         = st;
    if (is_nul) begin
      st_nxt = ST_RESET;
    end else if (is_delim) begin
      st_nxt = upd;
    end else begin
      st_nxt.in_token = 1'b1;
      if (!st.in_token) begin
        st_nxt.first_dollar = (item.ch == CH_DOLLAR);
      end
      st_nxt.token_len = (cur_len == 2'd2) ? 2'd2 : cur_len + 2'd1;
      if (!cur_bad && is_digit) begin
        st_nxt.token_bad = 1'b0;
        if (prod > {4'b0, VAL_MAX}) begin
          st_nxt.token_value = VAL_MAX;
          st_nxt.sat         = 1'b1;
        end else begin
          st_nxt.token_value = prod[ValW-1:0];
        end
      end else begin
        st_nxt.token_value = cur_value;
        st_nxt.token_bad   = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/src_checker.sv -----
module src_checker import src_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_data.ch == CH_NUL), 2))
    else $error("result without a terminating NUL item");

endmodule

bind selector_range_counter src_checker u_src_checker (.*);
